### design/mfd_pkg.sv
// Shared constants, types and the CRC-16 byte step for the Modbus RTU frame detector.
// No dependencies.
`default_nettype none

package mfd_pkg;

  localparam int unsigned FRAME_LEN_DEF = 8;

  localparam logic [7:0]  ADDR_RESET = 8'h01;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_LSB    = 16'h0001;

  // Status of the serial CRC unit towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } mfd_crc_sts_t;

  // One byte of reflected CRC-16: eight shift steps on a 16-bit value
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_LSB) != 16'h0000) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/modbus_rtu_frame_detector_top.sv
// Modbus RTU frame detector, top level: byte window, fill count, control and output register.
// An accepted byte goes to ST_CHK; when the window is full and addressed to us the serial
// CRC runs one byte per cycle over FRAME_LEN-2 bytes before ST_RES, else ST_RES follows.
// A new byte is taken only in ST_IDLE, after the result has gone to the output register.
// Reset (async, active low) clears fill count, control and output valid; address reads 1.
// Depends on mfd_pkg and mfd_crc_ser.
`default_nettype none

module modbus_rtu_frame_detector_top #(
  parameter int unsigned FRAME_LEN = mfd_pkg::FRAME_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: slave_address
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] function_code, [23:8] start_register,
                                           // [39:24] count_or_value
  output logic [0:0]       m_axis_tuser    // [0] frame_ok
);
  import mfd_pkg::*;

  localparam int unsigned FW     = $clog2(FRAME_LEN + 1);
  localparam int unsigned NBYTES = FRAME_LEN - 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for a byte
    ST_CHK  = 4'b0010,  // window updated, decide whether to check
    ST_CRC  = 4'b0100,  // serial CRC running
    ST_RES  = 4'b1000   // result ready, waiting for the output register
  } state_e;

  state_e          state_q, state_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [7:0]      addr_q;
  logic [7:0]      win_q [FRAME_LEN];   // oldest byte at index 0
  logic            ok_q, ok_d;
  logic            m_valid_q, m_valid_d;
  logic [39:0]     m_data_q, m_data_d;
  logic            m_user_q, m_user_d;

  logic                  in_acc;
  logic                  crc_start;
  mfd_crc_sts_t          crc_sts;
  logic [15:0]           crc_val;
  logic [8*NBYTES-1:0]   crc_data;
  logic [7:0]            pay_b [1:5];
  logic                  out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Bytes at or past the CRC bytes read as zero in the payload fields
  for (genvar k = 1; k <= 5; k++) begin : g_pay
    if (k + 2 < FRAME_LEN) begin : g_in
      assign pay_b[k] = win_q[k];
    end else begin : g_out
      assign pay_b[k] = 8'h00;
    end
  end

  for (genvar j = 0; j < NBYTES; j++) begin : g_crc_data
    assign crc_data[8*j +: 8] = win_q[j];
  end

  mfd_crc_ser #(
    .NBYTES (NBYTES)
  ) u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crc_start),
    .data_i  (crc_data),
    .sts_o   (crc_sts),
    .crc_o   (crc_val)
  );

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ok_d      = ok_q;
    crc_start = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (fill_q != FW'(FRAME_LEN)) begin
            fill_d = fill_q + FW'(1);
          end
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (fill_q == FW'(FRAME_LEN) && win_q[0] == addr_q) begin
          crc_start = 1'b1;
          state_d   = ST_CRC;
        end else begin
          ok_d    = 1'b0;
          state_d = ST_RES;
        end
      end
      ST_CRC: begin
        if (crc_sts.done) begin
          // CRC sent low byte first
          ok_d = (crc_val == {win_q[FRAME_LEN-1], win_q[FRAME_LEN-2]});
          if (crc_val == {win_q[FRAME_LEN-1], win_q[FRAME_LEN-2]}) begin
            fill_d = '0;
          end
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = ok_q;
          m_data_d  = ok_q ? {pay_b[4], pay_b[5], pay_b[2], pay_b[3], pay_b[1]} : 40'h0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Window shift register and result payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[FRAME_LEN-1] <= s_axis_tdata;
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    ok_q     <= ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      addr_q    <= ADDR_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  // no byte taken while the CRC unit is working
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !crc_sts.busy)
    else $error("byte accepted while CRC busy");

  // CRC completion only seen while waiting for it
  a_done_in_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_sts.done |-> (state_q == ST_CRC))
    else $error("CRC done outside CRC state");

  // fill count saturates at the frame length
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(FRAME_LEN))
    else $error("fill count past frame length");

  // a rejected window carries zero payload
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 40'h0))
    else $error("payload not zero without frame");

  // a check is only started on a full window
  a_start_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_start |-> (fill_q == FW'(FRAME_LEN)))
    else $error("CRC started on partial window");

endmodule

`default_nettype wire

### design/mfd_crc_ser.sv
// Byte-serial CRC-16 unit: scan shift register, CRC register and byte counter.
// Depends on mfd_pkg.
`default_nettype none

module mfd_crc_ser #(
  parameter int unsigned NBYTES = mfd_pkg::FRAME_LEN_DEF - 2
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [8*NBYTES-1:0]     data_i,   // byte 0 in the lowest bits
  output mfd_pkg::mfd_crc_sts_t        sts_o,
  output logic [15:0]                  crc_o
);
  import mfd_pkg::*;

  localparam int unsigned CW = $clog2(NBYTES + 1);

  logic [8*NBYTES-1:0] scan_q, scan_d;
  logic [15:0]         crc_q, crc_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  always_comb begin
    scan_d = scan_q;
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      scan_d = data_i;
      crc_d  = CRC_INIT;
      cnt_d  = CW'(NBYTES);
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d  = crc_byte(crc_q, scan_q[7:0]);
      scan_d = scan_q >> 8;
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    crc_q  <= crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign crc_o      = crc_q;

endmodule

`default_nettype wire
